// ----- rtl/dense_matrix_multiply_assert.svh -----
// assertion macros for dense_matrix_multiply
`ifndef DENSE_MATRIX_MULTIPLY_ASSERT_SVH
`define DENSE_MATRIX_MULTIPLY_ASSERT_SVH

// property that holds on every clock edge outside reset
`define DMM_ASSERT(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("dmm check failed");

// implication checked in the next cycle
`define DMM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("dmm check failed");

`endif

// ----- rtl/dmm_pkg.sv -----
// ---------------------------------------------------------------------------
// dmm_pkg
// types, codes and constants shared by the matrix multiply block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dmm_pkg;

  localparam int unsigned MaxDim   = 8;
  localparam int unsigned ElemBits = 16;
  localparam int unsigned AccBits  = 48;
  localparam int unsigned IdxBits  = $clog2(MaxDim);
  localparam int unsigned AddrBits = 2 * IdxBits;
  localparam int unsigned DimBits  = 4;
  localparam int unsigned CmdDepth = 2;

  typedef enum logic [1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_ROWS_A     = 2'd0,
    REG_INNER_DIM  = 2'd1,
    REG_COLS_B     = 2'd2,
    REG_ACCUMULATE = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]                 func;
    logic [2:0]                 row_index;
    logic [2:0]                 col_index;
    logic signed [ElemBits-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                out_row;
    logic [2:0]                out_col;
    logic signed [AccBits-1:0] product_value;
    logic                      last;
  } out_item_t;

  // command passed from front to back
  typedef struct packed {
    logic                clear;
    logic [IdxBits-1:0]  nr_m1;
    logic [IdxBits-1:0]  nk_m1;
    logic [IdxBits-1:0]  nc_m1;
    logic                accumulate;
  } cmd_t;

  function automatic logic [IdxBits-1:0] clamp_dim(input logic [DimBits-1:0] v);
    logic [IdxBits-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v >= DimBits'(MaxDim)) begin
      r = IdxBits'(MaxDim - 1);
    end else begin
      r = IdxBits'(v - DimBits'(1));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dmm_front.sv -----
// ---------------------------------------------------------------------------
// dmm_front
// accepts items, writes operand stores, queues compute and clear commands
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dmm_front import dmm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire in_item_t            in_item_i,
  input  wire logic [DimBits-1:0]  rows_a_i,
  input  wire logic [DimBits-1:0]  inner_dim_i,
  input  wire logic [DimBits-1:0]  cols_b_i,
  input  wire logic                accumulate_i,
  input  wire logic                busy_i,
  output logic                     a_we_o,
  output logic                     b_we_o,
  output logic [AddrBits-1:0]      ld_addr_o,
  output logic signed [ElemBits-1:0] ld_data_o,
  output logic                     cmd_valid_o,
  output cmd_t                     cmd_o,
  input  wire logic                cmd_ready_i
);

  cmd_t cmd_mem_q [CmdDepth];
  logic [$clog2(CmdDepth)-1:0] wr_ptr_q, rd_ptr_q;
  logic [$clog2(CmdDepth):0]   cnt_q;
  logic acc, is_cmd, cmd_push, cmd_pop;
  cmd_t new_cmd;

  // a load item waits until every earlier command has finished with the stores
  assign full    = (cnt_q == ($clog2(CmdDepth)+1)'(CmdDepth)) ||
                   (!is_cmd && (cnt_q != '0 || busy_i));
  assign acc     = push && !full;
  assign is_cmd  = in_item_i.func == FUNC_COMPUTE || in_item_i.func == FUNC_CLEAR;
  assign cmd_push = acc && is_cmd;
  assign cmd_pop  = cmd_valid_o && cmd_ready_i;

  assign a_we_o    = acc && in_item_i.func == FUNC_LOAD_A;
  assign b_we_o    = acc && in_item_i.func == FUNC_LOAD_B;
  assign ld_addr_o = {in_item_i.row_index, in_item_i.col_index};
  assign ld_data_o = in_item_i.elem_value;

  always_comb begin
    new_cmd.clear      = in_item_i.func == FUNC_CLEAR;
    new_cmd.nr_m1      = clamp_dim(rows_a_i);
    new_cmd.nk_m1      = clamp_dim(inner_dim_i);
    new_cmd.nc_m1      = clamp_dim(cols_b_i);
    new_cmd.accumulate = accumulate_i;
  end

  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = cmd_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (cmd_push) begin
      cmd_mem_q[wr_ptr_q] <= new_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (cmd_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (cmd_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + ($clog2(CmdDepth)+1)'(cmd_push) - ($clog2(CmdDepth)+1)'(cmd_pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dmm_back.sv -----
// ---------------------------------------------------------------------------
// dmm_back
// runs the multiply-accumulate sequence, emits results and clears the result store valid bits
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dmm_back import dmm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  a_we_i,
  input  wire logic                  b_we_i,
  input  wire logic [AddrBits-1:0]   ld_addr_i,
  input  wire logic signed [ElemBits-1:0] ld_data_i,
  input  wire logic                  cmd_valid_i,
  input  wire cmd_t                  cmd_i,
  output logic                       cmd_ready_o,
  output logic                       busy_o,
  output logic                       out_valid_o,
  output out_item_t                  out_item_o,
  input  wire logic                  out_ready_i
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_INIT  = 6'b000100,
    ST_MAC   = 6'b001000,
    ST_STORE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  localparam logic signed [AccBits-1:0] AccMax = {1'b0, {(AccBits-1){1'b1}}};
  localparam logic signed [AccBits-1:0] AccMin = {1'b1, {(AccBits-1){1'b0}}};

  state_e state_q, state_d;
  logic signed [ElemBits-1:0] a_mem [MaxDim*MaxDim];
  logic signed [ElemBits-1:0] b_mem [MaxDim*MaxDim];
  logic signed [AccBits-1:0]  c_mem [MaxDim*MaxDim];
  logic [MaxDim*MaxDim-1:0]   c_vld_q;
  cmd_t cmd_q;
  logic [IdxBits-1:0] r_q, c_q, k_q;
  logic [IdxBits:0]   kr_q;
  logic signed [ElemBits-1:0] a_rd_q, b_rd_q;
  logic signed [AccBits-1:0]  c_rd_q, acc_q;
  logic signed [2*ElemBits-1:0] prod_q;
  logic prod_vld_q, mul_vld_q, rd_vld_q;
  logic signed [AccBits:0] sum;
  logic signed [AccBits-1:0] sat;
  out_item_t out_q;
  logic out_vld_q;
  logic last_k;
  logic emit_go;

  assign cmd_ready_o = state_q == ST_IDLE;
  assign busy_o      = state_q != ST_IDLE;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign emit_go     = state_q == ST_EMIT && (!out_vld_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (a_we_i) a_mem[ld_addr_i] <= ld_data_i;
    if (b_we_i) b_mem[ld_addr_i] <= ld_data_i;
    a_rd_q <= a_mem[{r_q, k_q}];
    b_rd_q <= b_mem[{k_q, c_q}];
    c_rd_q <= c_mem[{r_q, c_q}];
    if (state_q == ST_STORE) c_mem[{r_q, c_q}] <= acc_q;
    prod_q <= a_rd_q * b_rd_q;
  end

  assign sum = (AccBits+1)'(prod_q) + (AccBits+1)'(acc_q);
  always_comb begin
    if (sum > (AccBits+1)'(AccMax)) sat = AccMax;
    else if (sum < $signed({AccMin[AccBits-1], AccMin})) sat = AccMin;
    else sat = sum[AccBits-1:0];
  end

  assign last_k = k_q == cmd_q.nk_m1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (cmd_valid_i) state_d = cmd_i.clear ? ST_CLEAR : ST_INIT;
      ST_CLEAR: state_d = ST_IDLE;
      ST_INIT:  state_d = ST_MAC;
      ST_MAC:   if (!rd_vld_q && !mul_vld_q && !prod_vld_q) state_d = ST_STORE;
      ST_STORE: state_d = ST_EMIT;
      ST_EMIT:  if (!out_vld_q || out_ready_i) begin
                  if (r_q == cmd_q.nr_m1 && c_q == cmd_q.nc_m1) state_d = ST_IDLE;
                  else state_d = ST_INIT;
                end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      c_vld_q    <= '0;
      out_vld_q  <= 1'b0;
      r_q <= '0; c_q <= '0; k_q <= '0; kr_q <= '0;
      prod_vld_q <= 1'b0;
      mul_vld_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_go) out_vld_q <= 1'b1;
      else if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            r_q <= '0; c_q <= '0; k_q <= '0; kr_q <= '0;
          end
        end
        ST_CLEAR: c_vld_q <= '0;
        ST_INIT: begin
          k_q <= '0; kr_q <= '0;
          rd_vld_q <= 1'b1; mul_vld_q <= 1'b0; prod_vld_q <= 1'b0;
        end
        ST_MAC: begin
          // reads issued for k, operands registered in the next cycle, product after that
          rd_vld_q   <= rd_vld_q && !last_k;
          mul_vld_q  <= rd_vld_q;
          prod_vld_q <= mul_vld_q;
          if (rd_vld_q && !last_k) k_q <= k_q + 1'b1;
          if (kr_q < 2) kr_q <= kr_q + 1'b1;
        end
        ST_STORE: c_vld_q[{r_q, c_q}] <= 1'b1;
        ST_EMIT: begin
          if (!out_vld_q || out_ready_i) begin
            if (c_q == cmd_q.nc_m1) begin
              c_q <= '0;
              r_q <= r_q + 1'b1;
            end else begin
              c_q <= c_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    if (state_q == ST_MAC && kr_q == 1) begin
      acc_q <= (cmd_q.accumulate && c_vld_q[{r_q, c_q}]) ? c_rd_q : '0;
    end else if (state_q == ST_MAC && prod_vld_q) begin
      acc_q <= sat;
    end
    if (emit_go) begin
      out_q.out_row       <= r_q;
      out_q.out_col       <= c_q;
      out_q.product_value <= acc_q;
      out_q.last          <= r_q == cmd_q.nr_m1 && c_q == cmd_q.nc_m1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dense_matrix_multiply.sv -----
// ---------------------------------------------------------------------------
// dense_matrix_multiply
// fixed-point matrix product with operand stores and a result store
// ---------------------------------------------------------------------------
// Load items write the A or B store directly, but a load waits (full high)
// while a compute or clear item is queued or running. A compute item works
// through rows*cols results, using the single shared multiply-accumulate
// unit working one inner term per cycle; results leave through a one-entry
// output register. A clear item marks every result store entry empty. Up
// to two compute or clear items queue in front of the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module dense_matrix_multiply import dmm_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire in_item_t       in_item_i,
  output logic                empty,
  input  wire logic           pop,
  output out_item_t           out_item_o,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i
);

  logic [DimBits-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic accumulate_q;
  logic a_we, b_we, cmd_valid, cmd_ready, out_valid, back_busy;
  logic [AddrBits-1:0] ld_addr;
  logic signed [ElemBits-1:0] ld_data;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q     <= DimBits'(MaxDim);
      inner_dim_q  <= DimBits'(MaxDim);
      cols_b_q     <= DimBits'(MaxDim);
      accumulate_q <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_e'(cfg_index_i))
        REG_ROWS_A:     rows_a_q     <= cfg_data_i[DimBits-1:0];
        REG_INNER_DIM:  inner_dim_q  <= cfg_data_i[DimBits-1:0];
        REG_COLS_B:     cols_b_q     <= cfg_data_i[DimBits-1:0];
        REG_ACCUMULATE: accumulate_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  dmm_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_item_i,
    .rows_a_i(rows_a_q), .inner_dim_i(inner_dim_q), .cols_b_i(cols_b_q),
    .accumulate_i(accumulate_q), .busy_i(back_busy),
    .a_we_o(a_we), .b_we_o(b_we), .ld_addr_o(ld_addr), .ld_data_o(ld_data),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  dmm_back u_back (
    .clk_i, .rst_ni,
    .a_we_i(a_we), .b_we_i(b_we), .ld_addr_i(ld_addr), .ld_data_i(ld_data),
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .busy_o(back_busy),
    .out_valid_o(out_valid), .out_item_o(out_item_o), .out_ready_i(pop)
  );

  assign empty = !out_valid;

`include "dense_matrix_multiply_assert.svh"

  `DMM_ASSERT(a_cfg_ready_high, cfg_ready)
  `DMM_ASSERT(a_no_two_writes, !(a_we && b_we))
  `DMM_ASSERT_NEXT(a_out_holds, !empty && !pop, !empty)

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the dense matrix multiply block
// ---------------------------------------------------------------------------
// A short stimulus table covers the element extremes, every function, a zero
// size, and accumulate and clear. Random phases follow, one oversized. Each
// phase sets the sizes and the mode, loads every operand element that
// the product reads, adds stray loads and clears, then computes. Every
// product element is checked against a local model of the block. The item
// source sends in bursts, and the result side stalls on a changing mask.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import dmm_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int DrainWait = 40;
  localparam longint AccMax = (64'sd1 <<< (AccBits - 1)) - 1;
  localparam longint AccMin = -AccMax - 1;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e kind;
    in_item_t  item;
    reg_e      idx;
    logic [31:0] data;
    bit        has_exp;
    longint    exp_val;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  dense_matrix_multiply dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic signed [ElemBits-1:0] a_mem [MaxDim][MaxDim];
  logic signed [ElemBits-1:0] b_mem [MaxDim][MaxDim];
  longint      c_mem [MaxDim][MaxDim];
  logic [3:0]  rows_q, inner_q, cols_q;
  logic        accum_q;

  out_item_t   product_q [$];
  stim_row_t   stim_tbl [$];
  int          errors = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          idle_cnt = 0;

  function automatic int dim_eff(input logic [3:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return int'(v);
  endfunction

  function automatic void model_cfg(input reg_e idx, input logic [31:0] d);
    case (idx)
      REG_ROWS_A:     rows_q = d[3:0];
      REG_INNER_DIM:  inner_q = d[3:0];
      REG_COLS_B:     cols_q = d[3:0];
      REG_ACCUMULATE: accum_q = d[0];
      default: ;
    endcase
  endfunction

  function automatic void model_item(input in_item_t it);
    int nr, nk, nc;
    longint acc, p;
    out_item_t o;
    nr = dim_eff(rows_q);
    nk = dim_eff(inner_q);
    nc = dim_eff(cols_q);
    case (it.func)
      FUNC_LOAD_A: a_mem[it.row_index][it.col_index] = it.elem_value;
      FUNC_LOAD_B: b_mem[it.row_index][it.col_index] = it.elem_value;
      FUNC_CLEAR: begin
        for (int r = 0; r < MaxDim; r++)
          for (int c = 0; c < MaxDim; c++) c_mem[r][c] = 0;
      end
      default: begin
        for (int r = 0; r < nr; r++) begin
          for (int c = 0; c < nc; c++) begin
            acc = accum_q ? c_mem[r][c] : 0;
            for (int k = 0; k < nk; k++) begin
              p = longint'(a_mem[r][k]) * longint'(b_mem[k][c]);
              acc = acc + p;
              if (acc > AccMax) acc = AccMax;
              if (acc < AccMin) acc = AccMin;
            end
            c_mem[r][c] = acc;
            o.out_row = 3'(r);
            o.out_col = 3'(c);
            o.product_value = acc[AccBits-1:0];
            o.last = (r == nr - 1) && (c == nc - 1);
            product_q.push_back(o);
          end
        end
      end
    endcase
  endfunction

  function automatic void add_item(input func_e f, input int r, input int c,
                                   input int v, input bit has_exp = 0,
                                   input longint ev = 0);
    stim_row_t s;
    s.kind = ROW_ITEM;
    s.item.func = f;
    s.item.row_index = 3'(r);
    s.item.col_index = 3'(c);
    s.item.elem_value = 16'(v);
    s.idx = REG_ROWS_A;
    s.data = '0;
    s.has_exp = has_exp;
    s.exp_val = ev;
    stim_tbl.push_back(s);
  endfunction

  function automatic void add_cfg(input reg_e idx, input logic [31:0] d);
    stim_row_t s;
    s.kind = ROW_CFG;
    s.item = '0;
    s.idx = idx;
    s.data = d;
    s.has_exp = 0;
    s.exp_val = 0;
    stim_tbl.push_back(s);
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    push <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    model_item(it);
    items_sent++;
    burst_left--;
  endtask

  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (product_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_cfg(input reg_e idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    model_cfg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // result side
  logic [7:0] stall_mask = 8'hff;
  int         pop_cyc = 0;
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && pop && !empty) begin
      if (product_q.size() == 0) begin
        $display("%0t unexpected item row %0d col %0d value %0d", $time,
                 out_item_o.out_row, out_item_o.out_col, out_item_o.product_value);
        errors++;
      end else begin
        e = product_q.pop_front();
        if (e.out_row !== out_item_o.out_row) begin
          $display("%0t out_row exp %0d got %0d", $time, e.out_row, out_item_o.out_row);
          errors++;
        end
        if (e.out_col !== out_item_o.out_col) begin
          $display("%0t out_col exp %0d got %0d", $time, e.out_col, out_item_o.out_col);
          errors++;
        end
        if (e.product_value !== out_item_o.product_value) begin
          $display("%0t product_value exp %0d got %0d", $time, e.product_value,
                   out_item_o.product_value);
          errors++;
        end
        if (e.last !== out_item_o.last) begin
          $display("%0t last exp %0d got %0d", $time, e.last, out_item_o.last);
          errors++;
        end
      end
    end
    pop_cyc++;
    if (pop_cyc % 64 == 0) begin
      stall_mask <= ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom());
    end
    pop <= stall_mask[pop_cyc % 8];
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (idle_cnt >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t s;
    int phase;
    int nr, nk, nc;
    in_item_t it;
    for (int r = 0; r < MaxDim; r++)
      for (int c = 0; c < MaxDim; c++) c_mem[r][c] = 0;
    rows_q = 4'd8;
    inner_q = 4'd8;
    cols_q = 4'd8;
    accum_q = 1'b0;

    // zero size reads as one
    add_cfg(REG_ROWS_A, 32'd0);
    add_cfg(REG_INNER_DIM, 32'd1);
    add_cfg(REG_COLS_B, 32'd1);
    add_cfg(REG_ACCUMULATE, 32'd0);
    add_item(FUNC_LOAD_A, 0, 0, 32767);
    add_item(FUNC_LOAD_B, 0, 0, 32767);
    add_item(FUNC_COMPUTE, 0, 0, 0, 1, 64'sd1073676289);
    add_item(FUNC_LOAD_A, 0, 0, -32768);
    add_item(FUNC_COMPUTE, 0, 0, 0, 1, -64'sd1073709056);
    add_item(FUNC_LOAD_B, 0, 0, -32768);
    add_item(FUNC_COMPUTE, 7, 7, 16'hffff, 1, 64'sd1073741824);
    add_item(FUNC_LOAD_A, 7, 7, 16'h5555);
    add_item(FUNC_LOAD_B, 7, 7, 16'haaaa);
    add_item(FUNC_CLEAR, 5, 2, 16'h1234);
    add_item(FUNC_LOAD_A, 0, 0, 1);
    add_item(FUNC_LOAD_B, 0, 0, -1);
    add_item(FUNC_COMPUTE, 0, 0, 0, 1, -64'sd1);
    add_cfg(REG_ACCUMULATE, 32'd1);
    add_item(FUNC_COMPUTE, 0, 0, 0, 1, -64'sd2);
    add_item(FUNC_COMPUTE, 0, 0, 0, 1, -64'sd3);
    add_item(FUNC_CLEAR, 0, 0, 0);
    add_item(FUNC_COMPUTE, 0, 0, 0, 1, -64'sd1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (stim_tbl[i]) begin
      s = stim_tbl[i];
      if (s.kind == ROW_CFG) begin
        drain();
        write_cfg(s.idx, s.data);
      end else begin
        send_item(s.item);
        if (s.has_exp) product_q[$].product_value = s.exp_val[AccBits-1:0];
      end
    end

    phase = 0;
    while (items_sent < 170) begin
      drain();
      case (phase)
        1: begin nr = 15; nk = 15; nc = 15; end
        default: begin
          nr = $urandom_range(0, 3);
          nk = $urandom_range(0, 4);
          nc = $urandom_range(0, 3);
        end
      endcase
      write_cfg(REG_ROWS_A, {28'($urandom()), 4'(nr)});
      write_cfg(REG_INNER_DIM, {28'($urandom()), 4'(nk)});
      write_cfg(REG_COLS_B, {28'($urandom()), 4'(nc)});
      write_cfg(REG_ACCUMULATE, $urandom());
      nr = dim_eff(4'(nr));
      nk = dim_eff(4'(nk));
      nc = dim_eff(4'(nc));
      for (int r = 0; r < nr; r++)
        for (int k = 0; k < nk; k++) begin
          it.func = FUNC_LOAD_A;
          it.row_index = 3'(r);
          it.col_index = 3'(k);
          it.elem_value = rand_elem();
          send_item(it);
          if ($urandom_range(0, 9) == 0) begin
            it = in_item_t'($bits(in_item_t)'($urandom()));
            if (it.func == FUNC_COMPUTE) it.func = FUNC_LOAD_B;
            send_item(it);
          end
        end
      for (int k = 0; k < nk; k++)
        for (int c = 0; c < nc; c++) begin
          it.func = FUNC_LOAD_B;
          it.row_index = 3'(k);
          it.col_index = 3'(c);
          it.elem_value = rand_elem();
          send_item(it);
        end
      if ($urandom_range(0, 3) == 0) begin
        it = in_item_t'($bits(in_item_t)'($urandom()));
        it.func = FUNC_CLEAR;
        send_item(it);
      end
      repeat ($urandom_range(1, 2)) begin
        it = in_item_t'($bits(in_item_t)'($urandom()));
        it.func = FUNC_COMPUTE;
        send_item(it);
      end
      phase++;
    end

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
